// File: src/fnvm_pkg.sv
// Shared constants, types and the lane mixing function of the multilane FNV byte digest.
package fnvm_pkg;

	// Fixed lane geometry and field widths.
	localparam int LANE_SLOTS   = 8;
	localparam int LANE_DEFAULT = 8;
	localparam int LANE_W       = 3;
	localparam int WORD_W       = 32;
	localparam int BYTE_W       = 8;

	// Mixing constants.
	localparam logic [9:0]        LANE_STRIDE = 10'h03D;
	localparam logic [WORD_W-1:0] FNV_PRIME   = 32'h0100_0193;
	localparam logic [4:0]        BASE_SHIFT  = 5'd13;

	// Per-lane starting values, lane 0 first.
	localparam logic [WORD_W-1:0] LANE_SEED [LANE_SLOTS] = '{
		32'h811c_9dc5, 32'h9e37_79b9, 32'h85eb_ca6b, 32'hc2b2_ae35,
		32'h27d4_eb2f, 32'h1656_67b1, 32'hd3a2_646c, 32'hfd70_46c5
	};

	// Control handed from the input stage to the lane bank.
	typedef struct packed {
		logic              go;
		logic              last;
		logic [BYTE_W-1:0] data;
	} fnvm_step_t;

	// One byte step of one lane: xor in the offset byte, multiply, fold down.
	function automatic logic [WORD_W-1:0] mix_lane(
		input logic [WORD_W-1:0] h,
		input logic [BYTE_W-1:0] b,
		input logic [LANE_W-1:0] lane
	);
		logic [9:0]        addend;
		logic [WORD_W-1:0] x;
		logic [4:0]        sh;
		addend = {2'b00, b} + ({7'b0, lane} * LANE_STRIDE);
		x      = h ^ {22'b0, addend};
		x      = x * FNV_PRIME;
		sh     = BASE_SHIFT + {3'b000, lane[1:0]};
		x      = x ^ (x >> sh);
		return x;
	endfunction

endpackage

// File: src/fnvm_lane_bank.sv
// Bank of hash lanes: holds the running lane values and mixes one byte into all of them.
module fnvm_lane_bank #(
	parameter int LANE_COUNT = fnvm_pkg::LANE_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fnvm_pkg::fnvm_step_t   step,
	output logic [LANE_COUNT-1:0][fnvm_pkg::WORD_W-1:0] mixed
);

	logic [fnvm_pkg::WORD_W-1:0] hash_q [LANE_COUNT];

	// Every lane mixes the current byte in parallel.
	always_comb begin
		for (int n = 0; n < LANE_COUNT; n++) begin
			mixed[n] = fnvm_pkg::mix_lane(hash_q[n], step.data,
				fnvm_pkg::LANE_W'(n));
		end
	end

	// Keep the mixed values, or reload the seeds once a message ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < LANE_COUNT; n++) begin
				hash_q[n] <= fnvm_pkg::LANE_SEED[n];
			end
		end else if (step.go) begin
			for (int n = 0; n < LANE_COUNT; n++) begin
				hash_q[n] <= step.last ? fnvm_pkg::LANE_SEED[n] : mixed[n];
			end
		end
	end

endmodule

// File: src/multilane_fnv_byte_digest_top.sv
// Multilane FNV byte digest: byte stream in, one digest word per lane out.
// Rates: one byte per cycle unless stalled, one lane word per cycle while m_tready.
// The final byte passes the input register; its snapshot load raises m_tvalid.
// A message end stalls in the input register while the previous digest is still draining.
// Reset: every lane holds its seed, the input register and the digest buffer are empty.
module multilane_fnv_byte_digest_top #(
	parameter int LANE_COUNT = fnvm_pkg::LANE_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [2:0]  m_tuser,   // [2:0] lane_number
	output logic        m_tlast    // final_word
);

	localparam logic [fnvm_pkg::LANE_W-1:0] LAST_LANE = fnvm_pkg::LANE_W'(LANE_COUNT - 1);

	logic                       valid_s1;
	logic [fnvm_pkg::BYTE_W-1:0] byte_s1;
	logic                       last_s1;
	logic                       busy_q;
	logic [fnvm_pkg::LANE_W-1:0] lane_q;
	logic [fnvm_pkg::WORD_W-1:0] obuf_q [LANE_COUNT];
	logic                       out_xfer;
	logic                       obuf_free;
	logic                       step_go;
	logic                       load;
	fnvm_pkg::fnvm_step_t       step;
	logic [LANE_COUNT-1:0][fnvm_pkg::WORD_W-1:0] mixed;

	// Handshake control: a final byte waits until the digest buffer can take the snapshot.
	assign out_xfer  = m_tvalid && m_tready;
	assign obuf_free = !busy_q || (out_xfer && m_tlast);
	assign step_go   = valid_s1 && (!last_s1 || obuf_free);
	assign load      = step_go && last_s1;
	assign s_tready  = !valid_s1 || step_go;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	assign step.go   = step_go;
	assign step.last = last_s1;
	assign step.data = byte_s1;

	fnvm_lane_bank #(
		.LANE_COUNT(LANE_COUNT)
	) u_lane_bank (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.mixed (mixed)
	);

	// Digest buffer: snapshot of all lanes, shifted down one word per transfer.
	always_ff @(posedge clk) begin
		if (load) begin
			for (int n = 0; n < LANE_COUNT; n++) begin
				obuf_q[n] <= mixed[n];
			end
		end else if (out_xfer) begin
			for (int n = 0; n < LANE_COUNT - 1; n++) begin
				obuf_q[n] <= obuf_q[n+1];
			end
		end
	end

	// Output word counter and valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			lane_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			lane_q <= '0;
		end else if (out_xfer) begin
			if (m_tlast) begin
				busy_q <= 1'b0;
			end else begin
				lane_q <= lane_q + 1'b1;
			end
		end
	end

	assign m_tvalid = busy_q;
	assign m_tdata  = obuf_q[0];
	assign m_tuser  = lane_q;
	assign m_tlast  = busy_q && (lane_q == LAST_LANE);

	// A snapshot always starts a fresh digest at lane 0.
	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (m_tvalid && m_tuser == '0))
		else $error("digest did not start at lane 0 after snapshot");

	// The input side only stalls behind a message end.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && last_s1 && busy_q))
		else $error("input stalled without a pending message end");

	// The last lane word ends the digest unless a new snapshot replaces it.
	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && m_tlast && !load) |=> !m_tvalid)
		else $error("output still valid after final digest word");

	// Lane number never runs past the configured lane count.
	a_lane_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser <= LAST_LANE))
		else $error("lane number out of range");

endmodule

// File: test/multilane_fnv_byte_digest_top_tb.sv
// Self-checking testbench for the multilane FNV byte digest top level.
`timescale 1ns / 100ps

module multilane_fnv_byte_digest_top_tb;

	localparam int LANES       = fnvm_pkg::LANE_DEFAULT;
	localparam int RANDOM_BYTES = 400;
	localparam int CYCLE_LIMIT = 200000;

	// One digest word as it leaves the block.
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  lane;
		logic        fin;
	} digest_word_t;

	// Keeps a private copy of the lane hashes and the digest words still owed by the block.
	class digest_scoreboard;
		logic [31:0]  lane_state [LANES];
		digest_word_t owed_words [$];
		int           mismatches;

		function new();
			mismatches = 0;
			reload_seeds();
		endfunction

		function void reload_seeds();
			for (int n = 0; n < LANES; n++)
				lane_state[n] = fnvm_pkg::LANE_SEED[n];
		endfunction

		// Mixes an accepted byte into every lane and, on a message end, queues the digest.
		function void note_byte(logic [7:0] b, logic eom);
			logic [31:0]  h;
			digest_word_t dw;
			for (int n = 0; n < LANES; n++) begin
				h = lane_state[n];
				h = h ^ (32'(b) + 32'(n) * 32'h3d);
				h = h * fnvm_pkg::FNV_PRIME;
				h = h ^ (h >> (13 + (n % 4)));
				lane_state[n] = h;
			end
			if (eom) begin
				for (int n = 0; n < LANES; n++) begin
					dw.word = lane_state[n];
					dw.lane = 3'(n);
					dw.fin  = (n == LANES - 1);
					owed_words.push_back(dw);
				end
				reload_seeds();
			end
		endfunction

		// Compares one received digest word with the oldest owed word.
		function void check_word(logic [31:0] w, logic [2:0] lane, logic fin);
			digest_word_t want;
			if (owed_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected digest word %h lane %0d last %b", w, lane, fin);
				return;
			end
			want = owed_words.pop_front();
			if (w !== want.word || lane !== want.lane || fin !== want.fin) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Digest mismatch: expected %h lane %0d last %b, got %h lane %0d last %b",
						want.word, want.lane, want.fin, w, lane, fin);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	digest_scoreboard digest_sb = new();

	int  cycle_count;
	int  sent_bytes;
	bit  send_burst;
	int  recv_words;
	bit  recv_burst;

	multilane_fnv_byte_digest_top #(
		.LANE_COUNT(LANES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Offers one byte after a random gap and waits for its transfer.
	task automatic send_byte(input logic [7:0] b, input logic eom);
		int gap;
		if (sent_bytes % 32 == 0)
			send_burst = ($urandom_range(0, 3) == 0);
		sent_bytes++;
		gap = send_burst ? 0 : $urandom_range(0, 9);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			s_tdata  = 8'($urandom);
			s_tlast  = 1'($urandom);
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = b;
		s_tlast  = eom;
		do @(posedge clk); while (!s_tready);
		digest_sb.note_byte(b, eom);
	endtask

	// Sends a message of random bytes of the given length.
	task automatic send_message(input int len);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom), i == len - 1);
	endtask

	// Receiving side: random stalls per word, every transfer is checked.
	initial begin
		int gap;
		m_tready = 1'b0;
		forever begin
			if (recv_words % 40 == 0)
				recv_burst = ($urandom_range(0, 3) == 0);
			gap = recv_burst ? 0 : $urandom_range(0, 9);
			@(negedge clk);
			if (gap > 0) begin
				m_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			recv_words++;
			digest_sb.check_word(m_tdata, m_tuser, m_tlast);
		end
	end

	// Watchdog on the whole run.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("multilane_fnv_byte_digest_top_tb failed");
		$finish;
	end

	initial begin
		logic [7:0] pattern [4];
		int len;
		s_tvalid   = 1'b0;
		s_tdata    = 8'h00;
		s_tlast    = 1'b0;
		sent_bytes = 0;
		recv_words = 0;
		arst_n     = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed: one-byte messages at the byte extremes.
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
		// Alternating bit patterns in one message.
		pattern = '{8'h55, 8'haa, 8'h0f, 8'hf0};
		for (int i = 0; i < 4; i++)
			send_byte(pattern[i], i == 3);
		// Back-to-back message ends, so an end waits while the previous digest drains.
		send_byte(8'h01, 1'b1);
		send_byte(8'h80, 1'b1);
		send_byte(8'h7f, 1'b1);
		// A longer message of all ones and one of all zeros.
		for (int i = 0; i < 8; i++)
			send_byte(8'hff, i == 7);
		for (int i = 0; i < 4; i++)
			send_byte(8'h00, i == 3);

		// Random messages, mostly short, a few long.
		while (sent_bytes < RANDOM_BYTES + 21) begin
			case ($urandom_range(0, 19))
				0:       len = $urandom_range(20, 48);
				1, 2, 3: len = 1;
				default: len = $urandom_range(2, 10);
			endcase
			send_message(len);
		end
		@(negedge clk);
		s_tvalid = 1'b0;

		// Drain the remaining digest words, then allow for stray output.
		while (digest_sb.owed_words.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		if (digest_sb.mismatches == 0 && digest_sb.owed_words.size() == 0) begin
			$display("multilane_fnv_byte_digest_top_tb passed");
		end else begin
			$display("multilane_fnv_byte_digest_top_tb failed");
		end
		$finish;
	end

endmodule

// File: multilane_fnv_byte_digest_top.f
src/fnvm_pkg.sv
src/fnvm_lane_bank.sv
src/multilane_fnv_byte_digest_top.sv
test/multilane_fnv_byte_digest_top_tb.sv
